>>> hw/rtl/tss_pkg.sv
package tss_pkg;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 4;
    localparam int OUT_BITS    = COORD_BITS + FRAC_BITS;
    // quotient magnitude never exceeds |dx| << FRAC_BITS
    localparam int QUO_BITS    = COORD_BITS + FRAC_BITS;
    localparam int PROD_BITS   = 2 * COORD_BITS;
    localparam int REM_BITS    = PROD_BITS + FRAC_BITS;
    localparam int DEN_SH_BITS = COORD_BITS + QUO_BITS - 1;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VERTEX_A_X = 3'd0,
        REG_VERTEX_A_Y = 3'd1,
        REG_VERTEX_B_X = 3'd2,
        REG_VERTEX_B_Y = 3'd3,
        REG_VERTEX_C_X = 3'd4,
        REG_VERTEX_C_Y = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } vertex_t;

    // edge setup before the multiply
    typedef struct packed {
        logic [COORD_BITS-1:0] dy;
        logic [COORD_BITS-1:0] dx_mag;
        logic                  neg;
        logic [COORD_BITS-1:0] den;
        logic [COORD_BITS-1:0] base;
    } edge_t;

    typedef struct packed {
        logic  in_range;
        edge_t edge_split;
        edge_t edge_long;
    } front_t;

    // one divider lane as it walks down the cell chain
    typedef struct packed {
        logic [REM_BITS-1:0]    rem;
        logic [DEN_SH_BITS-1:0] den_sh;
        logic [QUO_BITS-1:0]    quo;
        logic                   neg;
        logic [COORD_BITS-1:0]  base;
    } lane_t;

    typedef struct packed {
        logic  in_range;
        lane_t lane_split;
        lane_t lane_long;
    } div_stage_t;

endpackage

>>> hw/rtl/tss_if.sv
interface tss_row_if;
    logic                           valid;
    logic                           ready;
    logic [tss_pkg::COORD_BITS-1:0] row;

    modport source (output valid, output row, input ready);
    modport sink (input valid, input row, output ready);
endinterface

interface tss_span_if;
    logic                         valid;
    logic                         ready;
    logic                         row_in_range;
    logic [tss_pkg::OUT_BITS-1:0] x_split_edge;
    logic [tss_pkg::OUT_BITS-1:0] x_long_edge;

    modport source (output valid, output row_in_range, output x_split_edge,
                    output x_long_edge, input ready);
    modport sink (input valid, input row_in_range, input x_split_edge,
                  input x_long_edge, output ready);
endinterface

>>> hw/rtl/tss_front.sv
module tss_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    tss_row_if.sink              req,
    input  tss_pkg::vertex_t     vtx_a,
    input  tss_pkg::vertex_t     vtx_b,
    input  tss_pkg::vertex_t     vtx_c,
    output logic                 valid_out,
    output tss_pkg::div_stage_t  data_out,
    input  logic                 ready_in
);

    function automatic tss_pkg::edge_t make_edge(
        input tss_pkg::vertex_t                p,
        input tss_pkg::vertex_t                q,
        input logic [tss_pkg::COORD_BITS-1:0]  r,
        input logic                            keep
    );
        tss_pkg::edge_t e;
        e.dy   = r - p.y;
        e.base = p.x;
        if (keep)
        begin
            e.neg    = (q.x < p.x);
            e.dx_mag = (q.x < p.x) ? (p.x - q.x) : (q.x - p.x);
            e.den    = q.y - p.y;
        end
        else
        begin
            e.neg    = 1'b0;
            e.dx_mag = '0;
            e.den    = tss_pkg::COORD_BITS'(1);
        end
        return e;
    endfunction

    function automatic tss_pkg::lane_t make_lane(input tss_pkg::edge_t e);
        tss_pkg::lane_t                  l;
        logic [tss_pkg::PROD_BITS-1:0]   prod;
        prod     = tss_pkg::PROD_BITS'(e.dy) * tss_pkg::PROD_BITS'(e.dx_mag);
        l.rem    = tss_pkg::REM_BITS'(prod) << tss_pkg::FRAC_BITS;
        l.den_sh = tss_pkg::DEN_SH_BITS'(e.den) << (tss_pkg::QUO_BITS - 1);
        l.quo    = '0;
        l.neg    = e.neg;
        l.base   = e.base;
        return l;
    endfunction

    tss_pkg::vertex_t    st;
    tss_pkg::vertex_t    sm;
    tss_pkg::vertex_t    sb;
    tss_pkg::vertex_t    tmp;
    logic                in_range;
    logic                use_lower;
    logic                flat_lower;
    tss_pkg::front_t     a_next;
    logic                a_valid_reg;
    tss_pkg::front_t     a_data_reg;
    logic                a_ready;
    tss_pkg::div_stage_t b_next;
    logic                b_valid_reg;
    tss_pkg::div_stage_t b_data_reg;
    logic                b_ready;

    // stable three-swap sort by y
    always_comb
    begin
        st  = vtx_a;
        sm  = vtx_b;
        sb  = vtx_c;
        tmp = '0;
        if (st.y > sm.y)
        begin
            tmp = st;
            st  = sm;
            sm  = tmp;
        end
        if (sm.y > sb.y)
        begin
            tmp = sm;
            sm  = sb;
            sb  = tmp;
        end
        if (sm.y < st.y)
        begin
            tmp = sm;
            sm  = st;
            st  = tmp;
        end
    end

    always_comb
    begin
        in_range   = (req.row > st.y) && (req.row <= sb.y);
        use_lower  = (req.row >= sm.y) || (sm.y == st.y);
        flat_lower = (sb.y == sm.y);
        a_next.in_range = in_range;
        if (use_lower)
            a_next.edge_split = make_edge(sm, sb, req.row, in_range && !flat_lower);
        else
            a_next.edge_split = make_edge(st, sm, req.row, in_range);
        a_next.edge_long = make_edge(st, sb, req.row, in_range);
    end

    always_comb
    begin
        b_next.in_range   = a_data_reg.in_range;
        b_next.lane_split = make_lane(a_data_reg.edge_split);
        b_next.lane_long  = make_lane(a_data_reg.edge_long);
    end

    assign b_ready   = !b_valid_reg || ready_in;
    assign a_ready   = !a_valid_reg || b_ready;
    assign req.ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= req.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && req.valid)
            a_data_reg <= a_next;
        if (b_ready && a_valid_reg)
            b_data_reg <= b_next;
    end

    assign valid_out = b_valid_reg;
    assign data_out  = b_data_reg;

endmodule

>>> hw/rtl/tss_div_cell.sv
module tss_div_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  tss_pkg::div_stage_t  data_in,
    output logic                 ready_out,
    output logic                 valid_out,
    output tss_pkg::div_stage_t  data_out,
    input  logic                 ready_in
);

    // one restoring step: one quotient bit per lane
    function automatic tss_pkg::lane_t div_step(input tss_pkg::lane_t cur);
        tss_pkg::lane_t                 nxt;
        logic [tss_pkg::REM_BITS-1:0]   den_ext;
        logic                           take;
        nxt     = cur;
        den_ext = tss_pkg::REM_BITS'(cur.den_sh);
        take    = (cur.rem >= den_ext);
        if (take)
            nxt.rem = cur.rem - den_ext;
        nxt.quo    = {cur.quo[tss_pkg::QUO_BITS-2:0], take};
        nxt.den_sh = cur.den_sh >> 1;
        return nxt;
    endfunction

    logic                valid_reg;
    tss_pkg::div_stage_t data_reg;
    tss_pkg::div_stage_t data_next;

    always_comb
    begin
        data_next.in_range   = data_in.in_range;
        data_next.lane_split = div_step(data_in.lane_split);
        data_next.lane_long  = div_step(data_in.lane_long);
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> hw/rtl/triangle_scanline_span_core.sv
// Channel  Dir  Payload                                     Transfer
// req      in   row                                         valid & ready
// span     out  row_in_range, x_split_edge, x_long_edge     valid & ready
// cfg      in   cfg_index, cfg_data                         cfg_we (no wait)
//
// Path from request to result: front-end registers a and b, the divider chain
// (one cell per quotient bit, both edges divided side by side in every cell)
// and the output register; x crossings are 10.4 fixed point. One transaction
// per cycle sustained while span keeps taking results.
// Reset: rst_n clears all valid flags and the vertex registers to zero.
// Stalls: every stage holds only while its successor is full and stalled, so
// bubbles close up and req keeps taking rows while span waits, until full.
module triangle_scanline_span_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    tss_row_if.sink                             req,
    tss_span_if.source                          span,
    input  logic                                cfg_we,
    input  logic [tss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tss_pkg::COORD_BITS-1:0]      cfg_data
);

    // Final fix-up: floor for negative slopes, then add the top x.
    function automatic logic [tss_pkg::OUT_BITS-1:0] finish(input tss_pkg::lane_t l);
        logic [tss_pkg::OUT_BITS-1:0] scaled;
        logic [tss_pkg::QUO_BITS:0]   adj;
        scaled = tss_pkg::OUT_BITS'(l.base) << tss_pkg::FRAC_BITS;
        adj    = {1'b0, l.quo} +
                 (tss_pkg::QUO_BITS+1)'(l.neg && (l.rem != '0));
        if (l.neg)
            return scaled - tss_pkg::OUT_BITS'(adj);
        else
            return scaled + tss_pkg::OUT_BITS'(adj);
    endfunction

    // Vertex registers: the user must write them only while the core is idle; the core does not enforce this.
    tss_pkg::vertex_t vtx_a_reg;
    tss_pkg::vertex_t vtx_b_reg;
    tss_pkg::vertex_t vtx_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_a_reg <= '0;
            vtx_b_reg <= '0;
            vtx_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tss_pkg::REG_VERTEX_A_X: vtx_a_reg.x <= cfg_data;
                tss_pkg::REG_VERTEX_A_Y: vtx_a_reg.y <= cfg_data;
                tss_pkg::REG_VERTEX_B_X: vtx_b_reg.x <= cfg_data;
                tss_pkg::REG_VERTEX_B_Y: vtx_b_reg.y <= cfg_data;
                tss_pkg::REG_VERTEX_C_X: vtx_c_reg.x <= cfg_data;
                tss_pkg::REG_VERTEX_C_Y: vtx_c_reg.y <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // Cell chain: slot 0 is fed by the front end, slot QUO_BITS feeds the
    // output register.
    logic                chain_valid [tss_pkg::QUO_BITS+1];
    tss_pkg::div_stage_t chain_data  [tss_pkg::QUO_BITS+1];
    logic                chain_ready [tss_pkg::QUO_BITS+1];

    tss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .vtx_a     (vtx_a_reg),
        .vtx_b     (vtx_b_reg),
        .vtx_c     (vtx_c_reg),
        .valid_out (chain_valid[0]),
        .data_out  (chain_data[0]),
        .ready_in  (chain_ready[0])
    );

    for (genvar g = 0; g < tss_pkg::QUO_BITS; g++)
    begin : g_cell
        tss_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[g]),
            .data_in   (chain_data[g]),
            .ready_out (chain_ready[g]),
            .valid_out (chain_valid[g+1]),
            .data_out  (chain_data[g+1]),
            .ready_in  (chain_ready[g+1])
        );
    end

    // Output register.
    logic                         span_valid_reg;
    logic                         in_range_reg;
    logic [tss_pkg::OUT_BITS-1:0] x_split_reg;
    logic [tss_pkg::OUT_BITS-1:0] x_long_reg;
    logic                         in_range_next;
    logic [tss_pkg::OUT_BITS-1:0] x_split_next;
    logic [tss_pkg::OUT_BITS-1:0] x_long_next;
    logic                         out_ready;

    assign out_ready                      = !span_valid_reg || span.ready;
    assign chain_ready[tss_pkg::QUO_BITS] = out_ready;

    always_comb
    begin
        in_range_next = chain_data[tss_pkg::QUO_BITS].in_range;
        if (in_range_next)
        begin
            x_split_next = finish(chain_data[tss_pkg::QUO_BITS].lane_split);
            x_long_next  = finish(chain_data[tss_pkg::QUO_BITS].lane_long);
        end
        else
        begin
            // row outside the triangle: both crossings read zero
            x_split_next = '0;
            x_long_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_valid_reg <= 1'b0;
        else if (out_ready)
            span_valid_reg <= chain_valid[tss_pkg::QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && chain_valid[tss_pkg::QUO_BITS])
        begin
            in_range_reg <= in_range_next;
            x_split_reg  <= x_split_next;
            x_long_reg   <= x_long_next;
        end
    end

    assign span.valid        = span_valid_reg;
    assign span.row_in_range = in_range_reg;
    assign span.x_split_edge = x_split_reg;
    assign span.x_long_edge  = x_long_reg;

`ifndef SYNTHESIS
    // An open output slot lets the whole chain move, so req must be ready.
    a_req_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!span.valid || span.ready) |-> req.ready)
        else $error("req stalled while output slot open");

    // Out-of-range rows carry zero crossings.
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (span.valid && !span.row_in_range) |->
            (span.x_split_edge == '0 && span.x_long_edge == '0))
        else $error("nonzero crossing on out-of-range row");

    // A crossing lies between vertex x values, so never past the last pixel.
    a_crossing_bound: assert property (@(posedge clk) disable iff (!rst_n)
        span.valid |->
            (span.x_split_edge <= ({tss_pkg::OUT_BITS{1'b1}} << tss_pkg::FRAC_BITS) &&
             span.x_long_edge <= ({tss_pkg::OUT_BITS{1'b1}} << tss_pkg::FRAC_BITS)))
        else $error("crossing beyond coordinate range");
`endif

endmodule
